// ===== hw/rtl/md5_pkg.sv =====
// Shared types, constants, round tables and microcode ROM of the MD5 digest block.
package md5_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 61;

  // Input command codes.
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_LAST = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Program step addresses.
  localparam logic [2:0] STEP_WAIT   = 3'd0;
  localparam logic [2:0] STEP_BLOCK  = 3'd1;
  localparam logic [2:0] STEP_PAD    = 3'd2;
  localparam logic [2:0] STEP_OVF    = 3'd3;
  localparam logic [2:0] STEP_ZERO   = 3'd4;
  localparam logic [2:0] STEP_LENGTH = 3'd5;
  localparam logic [2:0] STEP_FINAL  = 3'd6;
  localparam logic [2:0] STEP_EMIT   = 3'd7;

  localparam logic [WordW-1:0] INIT_A = 32'h67452301;
  localparam logic [WordW-1:0] INIT_B = 32'hefcdab89;
  localparam logic [WordW-1:0] INIT_C = 32'h98badcfe;
  localparam logic [WordW-1:0] INIT_D = 32'h10325476;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_ROUNDS,
    OP_PAD,
    OP_ZERO,
    OP_LENGTH,
    OP_EMIT
  } md5_op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_FIN,
    COND_OVF
  } md5_cond_t;

  // One control word: the operation, a branch condition, and two targets.
  typedef struct packed {
    md5_op_t   op;
    md5_cond_t cond;
    logic [2:0] nxt;
    logic [2:0] jmp;
  } md5_uword_t;

  function automatic md5_uword_t md5_ucode(input logic [2:0] pc);
    md5_uword_t u;
    case (pc)
      STEP_WAIT:   u = '{OP_WAIT,   COND_NONE, STEP_PAD,    STEP_BLOCK};
      STEP_BLOCK:  u = '{OP_ROUNDS, COND_FIN,  STEP_WAIT,   STEP_PAD};
      STEP_PAD:    u = '{OP_PAD,    COND_OVF,  STEP_LENGTH, STEP_OVF};
      STEP_OVF:    u = '{OP_ROUNDS, COND_NONE, STEP_ZERO,   STEP_ZERO};
      STEP_ZERO:   u = '{OP_ZERO,   COND_NONE, STEP_LENGTH, STEP_LENGTH};
      STEP_LENGTH: u = '{OP_LENGTH, COND_NONE, STEP_FINAL,  STEP_FINAL};
      STEP_FINAL:  u = '{OP_ROUNDS, COND_NONE, STEP_EMIT,   STEP_EMIT};
      STEP_EMIT:   u = '{OP_EMIT,   COND_NONE, STEP_WAIT,   STEP_WAIT};
      default:     u = '{OP_WAIT,   COND_NONE, STEP_WAIT,   STEP_WAIT};
    endcase
    return u;
  endfunction

  function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
      2'd2:    g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
      default: g = 4'((r[3:0] << 3) - r[3:0]);
    endcase
    return g;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [WordW-1:0] md5_k(input logic [5:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/md5_message_digest.sv =====
// MD5 digest block: byte input, microcoded round sequencer, four-word digest output.
//
//  Channel  Handshake             Payload                              Direction
//  msg      msg_valid/msg_stall   command[1:0], data_byte[7:0]         in
//  dig      dig_valid/dig_stall   digest_word[31:0], word_index[1:0],  out
//                                 last_word
//
// An ordinary byte is absorbed at the wait step. A byte that fills a block runs
// 64 rounds at one round per cycle plus the chaining add, all in one shared
// round unit. Finishing a message runs the pad, length and final-block steps,
// plus a further block and a zero step when the padding spills into a second
// block, then four digest transfers.
// Reset is synchronous and restores the initial chaining words and a zero length.
// The input is stalled whenever the sequencer is not at its wait step; a stalled
// digest word holds until it is taken.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md5_pkg::md5_uword_t uw;

  logic [2:0]  pc;
  logic [2:0]  pc_next;
  logic [6:0]  rnd;
  logic [1:0]  idx;
  logic        pend;
  logic [md5_pkg::CountW-1:0] byte_count;
  logic [md5_pkg::WordW-1:0]  chain [4];
  logic [md5_pkg::WordW-1:0]  work  [4];
  logic [md5_pkg::WordW-1:0]  blk   [16];

  logic        msg_xfer;
  logic        dig_xfer;
  logic        absorb;
  logic        full_byte;
  logic        finish;
  logic        take_jmp;
  logic        step_done;
  logic [5:0]  pos;
  logic        byte_en;
  logic [7:0]  byte_val;

  logic [5:0]  r;
  logic [md5_pkg::WordW-1:0] f;
  logic [md5_pkg::WordW-1:0] sum;
  logic [2*md5_pkg::WordW-1:0] rot_wide;
  logic [md5_pkg::WordW-1:0] new_b;

  assign uw = md5_pkg::md5_ucode(pc);

  assign msg_stall = (uw.op != md5_pkg::OP_WAIT);
  assign msg_xfer  = msg_valid && !msg_stall;
  assign dig_valid = (uw.op == md5_pkg::OP_EMIT);
  assign dig_xfer  = dig_valid && !dig_stall;

  assign digest_word = chain[idx];
  assign word_index  = idx;
  assign last_word   = (idx == 2'd3);

  assign pos       = byte_count[5:0];
  assign absorb    = msg_xfer && (command == md5_pkg::CMD_DATA ||
                                  command == md5_pkg::CMD_LAST);
  assign full_byte = absorb && (pos == 6'd63);
  assign finish    = msg_xfer && (command == md5_pkg::CMD_LAST ||
                                  command == md5_pkg::CMD_END);

  // The pad step writes 0x80 through the same byte lane path as data.
  assign byte_en  = absorb || (uw.op == md5_pkg::OP_PAD);
  assign byte_val = (uw.op == md5_pkg::OP_PAD) ? 8'h80 : data_byte;

  // Round unit.
  assign r = rnd[5:0];
  always_comb begin
    case (r[5:4])
      2'd0:    f = (work[1] & work[2]) | (~work[1] & work[3]);
      2'd1:    f = (work[1] & work[3]) | (work[2] & ~work[3]);
      2'd2:    f = work[1] ^ work[2] ^ work[3];
      default: f = work[2] ^ (work[1] | ~work[3]);
    endcase
  end
  assign sum      = work[0] + f + md5_pkg::md5_k(r) + blk[md5_pkg::md5_msg_index(r)];
  assign rot_wide = {sum, sum} << md5_pkg::md5_rot(r);
  assign new_b    = work[1] + rot_wide[2*md5_pkg::WordW-1:md5_pkg::WordW];

  // Sequencer: branch conditions and step completion.
  always_comb begin
    case (uw.cond)
      md5_pkg::COND_FIN: take_jmp = pend;
      md5_pkg::COND_OVF: take_jmp = (pos >= 6'd56);
      default:           take_jmp = 1'b0;
    endcase
    case (uw.op)
      md5_pkg::OP_ROUNDS: step_done = rnd[6];
      md5_pkg::OP_EMIT:   step_done = dig_xfer && last_word;
      default:            step_done = 1'b1;
    endcase
    pc_next = pc;
    if (uw.op == md5_pkg::OP_WAIT) begin
      if (full_byte) begin
        pc_next = uw.jmp;
      end else if (finish) begin
        pc_next = uw.nxt;
      end
    end else if (step_done) begin
      pc_next = take_jmp ? uw.jmp : uw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= md5_pkg::STEP_WAIT;
      rnd        <= '0;
      idx        <= '0;
      pend       <= 1'b0;
      byte_count <= '0;
      chain[0]   <= md5_pkg::INIT_A;
      chain[1]   <= md5_pkg::INIT_B;
      chain[2]   <= md5_pkg::INIT_C;
      chain[3]   <= md5_pkg::INIT_D;
    end else begin
      pc <= pc_next;
      if (msg_xfer) begin
        pend <= (command == md5_pkg::CMD_LAST);
      end
      if (absorb) begin
        byte_count <= byte_count + md5_pkg::CountW'(1);
      end
      if (uw.op == md5_pkg::OP_ROUNDS) begin
        if (rnd[6]) begin
          rnd <= '0;
          for (int i = 0; i < 4; i++) begin
            chain[i] <= chain[i] + work[i];
          end
        end else begin
          rnd <= rnd + 7'd1;
        end
      end
      if (dig_xfer) begin
        idx <= idx + 2'd1;
        if (last_word) begin
          byte_count <= '0;
          chain[0]   <= md5_pkg::INIT_A;
          chain[1]   <= md5_pkg::INIT_B;
          chain[2]   <= md5_pkg::INIT_C;
          chain[3]   <= md5_pkg::INIT_D;
        end
      end
    end
  end

  // Datapath registers: working words and the message block.
  always_ff @(posedge clk) begin
    if (uw.op == md5_pkg::OP_ROUNDS) begin
      if (!rnd[6]) begin
        work[0] <= work[3];
        work[1] <= new_b;
        work[2] <= work[1];
        work[3] <= work[2];
      end
    end else begin
      // Outside the rounds the working words track the chaining words.
      for (int i = 0; i < 4; i++) begin
        work[i] <= chain[i];
      end
    end
    for (int w = 0; w < 16; w++) begin
      if (byte_en && (4'(w) == pos[5:2])) begin
        if (pos[1:0] == 2'd0) begin
          blk[w] <= {24'd0, byte_val};
        end else begin
          blk[w][8*pos[1:0] +: 8] <= byte_val;
        end
      end
      if ((uw.op == md5_pkg::OP_PAD) && (4'(w) > pos[5:2])) begin
        blk[w] <= '0;
      end
      if ((uw.op == md5_pkg::OP_ZERO) && (w < 14)) begin
        blk[w] <= '0;
      end
    end
    if (uw.op == md5_pkg::OP_LENGTH) begin
      blk[14] <= {byte_count[28:0], 3'd0};
      blk[15] <= byte_count[60:29];
    end
  end

  a_rnd_only_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (rnd != 7'd0) |-> (uw.op == md5_pkg::OP_ROUNDS))
    else $error("round counter running outside a rounds step");

  a_rnd_bound: assert property (@(posedge clk) disable iff (rst)
    (rnd[6]) |=> (rnd == 7'd0))
    else $error("round counter went past the chaining add");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (dig_xfer && last_word) |=> (byte_count == '0 && pc == md5_pkg::STEP_WAIT &&
                                 idx == 2'd0))
    else $error("block did not re-arm after the last digest word");

  a_emit_idle_rounds: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (rnd == 7'd0 && msg_stall))
    else $error("digest offered while rounds run or input open");

endmodule

// ===== verif/md5_message_digest_tb.sv =====
// Self-checking testbench for md5_message_digest: byte stream in, digest words out.
module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 300;

  // Round additive constants, round 0 in the most significant word.
  localparam logic [64*32-1:0] ROUND_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, four per group of sixteen rounds.
  localparam logic [16*5-1:0] ROT_AMOUNT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [127:0] EMPTY_DIGEST = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
  localparam logic [127:0] ABC_DIGEST   = 128'h98500190_b04fd23c_7d3f96d6_727fe128;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  slot;
    logic        is_last;
  } digest_beat_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [7:0]   value;
    bit           known;
    logic [127:0] digest;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        msg_valid;
  logic        msg_stall;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic        dig_valid;
  logic        dig_stall;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  md5_message_digest dut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .command     (command),
    .data_byte   (data_byte),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // Predictor state: chaining words, the block being filled and the byte length.
  logic [31:0] chain_word [4];
  logic [31:0] msg_block [16];
  logic [60:0] msg_len;

  digest_beat_t digest_expected[$];
  stim_row_t    directed_rows[$];
  int           error_count = 0;
  int           items_sent = 0;
  bit           steady = 1'b0;
  bit           hold_request = 1'b0;

  wire msg_take = msg_valid && !msg_stall;
  wire dig_take = dig_valid && !dig_stall;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void mix_block();
    logic [31:0] a, b, c, d, f, t;
    int g;
    int r;
    a = chain_word[0];
    b = chain_word[1];
    c = chain_word[2];
    d = chain_word[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + ROUND_K[(63 - r) * 32 +: 32] + msg_block[g];
      a = d;
      d = c;
      c = b;
      b = b + rotate_left(t, ROT_AMOUNT[(15 - ((r / 16) * 4 + r % 4)) * 5 +: 5]);
    end
    chain_word[0] += a;
    chain_word[1] += b;
    chain_word[2] += c;
    chain_word[3] += d;
  endfunction

  // The first byte of a word clears the rest of it.
  function automatic void place_byte(input int pos, input logic [7:0] v);
    if (pos % 4 == 0)
      msg_block[pos / 4] = {24'd0, v};
    else
      msg_block[pos / 4][(pos % 4) * 8 +: 8] = v;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    int pos;
    pos = int'(msg_len[5:0]);
    place_byte(pos, v);
    msg_len = msg_len + 61'd1;
    if (pos == 63)
      mix_block();
  endfunction

  function automatic logic [127:0] close_message();
    int pos;
    int w;
    logic [63:0] bits;
    logic [127:0] digest;
    pos = int'(msg_len[5:0]);
    bits = {msg_len, 3'b000};
    place_byte(pos, 8'h80);
    for (w = pos / 4 + 1; w < 16; w++)
      msg_block[w] = '0;
    // No room for the length after the pad byte: flush and start a zero block.
    if (pos >= 56) begin
      mix_block();
      for (w = 0; w < 14; w++)
        msg_block[w] = '0;
    end
    msg_block[14] = bits[31:0];
    msg_block[15] = bits[63:32];
    mix_block();
    digest = {chain_word[0], chain_word[1], chain_word[2], chain_word[3]};
    chain_word[0] = md5_pkg::INIT_A;
    chain_word[1] = md5_pkg::INIT_B;
    chain_word[2] = md5_pkg::INIT_C;
    chain_word[3] = md5_pkg::INIT_D;
    msg_len = '0;
    return digest;
  endfunction

  function automatic void predict_item(input logic [1:0] cmd, input logic [7:0] v,
                                       output bit closes, output logic [127:0] digest);
    closes = 1'b0;
    digest = '0;
    case (cmd)
      md5_pkg::CMD_DATA: absorb_byte(v);
      md5_pkg::CMD_LAST: begin
        absorb_byte(v);
        digest = close_message();
        closes = 1'b1;
      end
      md5_pkg::CMD_END: begin
        digest = close_message();
        closes = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] v,
                                  input bit known, input logic [127:0] digest);
    stim_row_t row;
    row.cmd = cmd;
    row.value = v;
    row.known = known;
    row.digest = digest;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] v, input bit known,
                           input logic [127:0] typed);
    bit closes;
    logic [127:0] digest;
    digest_beat_t beat;
    int k;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 7) begin
      msg_valid = 1'b0;
      @(negedge clk);
    end
    msg_valid = 1'b1;
    command = cmd;
    data_byte = v;
    do @(posedge clk); while (msg_stall);
    predict_item(cmd, v, closes, digest);
    if (closes) begin
      if (known)
        digest = typed;
      for (k = 0; k < 4; k++) begin
        beat.word = digest[127 - 32 * k -: 32];
        beat.slot = 2'(k);
        beat.is_last = (k == 3);
        digest_expected.push_back(beat);
      end
    end
  endtask

  // Random message of len bytes, ended either on its last byte or by a separate end.
  task automatic send_message(input int len);
    bit on_last;
    int i;
    on_last = (len > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4)
        send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0, '0);
      send_item((on_last && i == len - 1) ? md5_pkg::CMD_LAST : md5_pkg::CMD_DATA,
                8'($urandom_range(0, 255)), 1'b0, '0);
      items_sent++;
    end
    if (!on_last) begin
      send_item(md5_pkg::CMD_END, 8'($urandom_range(0, 255)), 1'b0, '0);
      items_sent++;
    end
  endtask

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && dig_take) begin
      if (digest_expected.size() == 0) begin
        report_mismatch("unexpected digest transfer", digest_word, '0);
      end else begin
        want = digest_expected.pop_front();
        if (digest_word !== want.word)
          report_mismatch("digest_word", digest_word, want.word);
        if (word_index !== want.slot)
          report_mismatch("word_index", 32'(word_index), 32'(want.slot));
        if (last_word !== want.is_last)
          report_mismatch("last_word", 32'(last_word), 32'(want.is_last));
      end
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin : receiver
    dig_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        dig_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        dig_stall = 1'b0;
      end else begin
        dig_stall = !steady && ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (msg_take || dig_take)
        stuck = 0;
      else
        stuck++;
    end
    $display("md5_message_digest test failed");
    $finish;
  end

  initial begin : stimulus
    int m;
    int len;
    rst = 1'b1;
    msg_valid = 1'b0;
    command = md5_pkg::CMD_DATA;
    data_byte = 8'h00;
    chain_word[0] = md5_pkg::INIT_A;
    chain_word[1] = md5_pkg::INIT_B;
    chain_word[2] = md5_pkg::INIT_C;
    chain_word[3] = md5_pkg::INIT_D;
    msg_len = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(md5_pkg::CMD_END,  8'h00, 1'b1, EMPTY_DIGEST);
    add_row(md5_pkg::CMD_END,  8'hff, 1'b1, EMPTY_DIGEST);
    add_row(CMD_UNUSED,        8'h5a, 1'b0, '0);
    add_row(md5_pkg::CMD_DATA, 8'h61, 1'b0, '0);
    add_row(CMD_UNUSED,        8'hff, 1'b0, '0);
    add_row(md5_pkg::CMD_DATA, 8'h62, 1'b0, '0);
    add_row(md5_pkg::CMD_LAST, 8'h63, 1'b1, ABC_DIGEST);
    add_row(md5_pkg::CMD_LAST, 8'h00, 1'b0, '0);
    add_row(md5_pkg::CMD_LAST, 8'hff, 1'b0, '0);
    add_row(md5_pkg::CMD_DATA, 8'h00, 1'b0, '0);
    add_row(md5_pkg::CMD_DATA, 8'hff, 1'b0, '0);
    add_row(md5_pkg::CMD_DATA, 8'h80, 1'b0, '0);
    add_row(md5_pkg::CMD_END,  8'h55, 1'b0, '0);
    add_row(CMD_UNUSED,        8'h00, 1'b0, '0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].known,
                directed_rows[i].digest);

    // Short messages first under a long receiver hold-off, then a padding spill,
    // a quiet stretch, a message crossing a block boundary, and random mixes.
    m = 0;
    while (m < 9 || items_sent < 100) begin
      if (m == 0)
        hold_request = 1'b1;
      steady = (m >= 5 && m <= 7);
      if (m < 4)
        len = $urandom_range(0, 3);
      else if (m == 4)
        len = $urandom_range(56, 63);
      else if (m <= 7)
        len = $urandom_range(0, 12);
      else if (m == 8)
        len = $urandom_range(64, 72);
      else if ($urandom_range(0, 9) < 7)
        len = $urandom_range(0, 12);
      else
        len = $urandom_range(50, 66);
      send_message(len);
      m++;
    end
    @(negedge clk);
    msg_valid = 1'b0;

    while (digest_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("md5_message_digest test passed");
    else
      $display("md5_message_digest test failed");
    $finish;
  end

endmodule
